/* rtl/core/ria_pkg.sv */
// ria_pkg: shared types, operation codes and helpers for the rv64im integer alu
// used by every module under rtl/core; depends on nothing

package ria_pkg;

	// operation codes
	localparam logic [4:0] OP_ADD    = 5'd0;
	localparam logic [4:0] OP_ADDW   = 5'd1;
	localparam logic [4:0] OP_SUB    = 5'd2;
	localparam logic [4:0] OP_SUBW   = 5'd3;
	localparam logic [4:0] OP_AND    = 5'd4;
	localparam logic [4:0] OP_OR     = 5'd5;
	localparam logic [4:0] OP_XOR    = 5'd6;
	localparam logic [4:0] OP_SLL    = 5'd7;
	localparam logic [4:0] OP_SRL    = 5'd8;
	localparam logic [4:0] OP_SRA    = 5'd9;
	localparam logic [4:0] OP_SLLW   = 5'd10;
	localparam logic [4:0] OP_SRLW   = 5'd11;
	localparam logic [4:0] OP_SRAW   = 5'd12;
	localparam logic [4:0] OP_SLT    = 5'd13;
	localparam logic [4:0] OP_SLTU   = 5'd14;
	localparam logic [4:0] OP_MUL    = 5'd15;
	localparam logic [4:0] OP_MULH   = 5'd16;
	localparam logic [4:0] OP_MULHSU = 5'd17;
	localparam logic [4:0] OP_MULHU  = 5'd18;
	localparam logic [4:0] OP_MULW   = 5'd19;
	localparam logic [4:0] OP_DIV    = 5'd20;
	localparam logic [4:0] OP_DIVU   = 5'd21;
	localparam logic [4:0] OP_DIVW   = 5'd22;
	localparam logic [4:0] OP_DIVUW  = 5'd23;
	localparam logic [4:0] OP_REM    = 5'd24;
	localparam logic [4:0] OP_REMU   = 5'd25;
	localparam logic [4:0] OP_REMW   = 5'd26;
	localparam logic [4:0] OP_REMUW  = 5'd27;

	// execution class picked by the front
	localparam logic [1:0] CLS_ALU = 2'd0;
	localparam logic [1:0] CLS_MUL = 2'd1;
	localparam logic [1:0] CLS_DIV = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [4:0]  operation;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
	} in_t;

	typedef struct packed {
		logic [63:0] result_value;
		logic        exception_flag;
	} out_t;

	// classified entry held in the queue
	typedef struct packed {
		logic [1:0]  cls;
		logic        word;
		logic        sgn;
		logic [4:0]  operation;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
	} dec_t;

	function automatic logic [63:0] sext32(input logic [31:0] x);
		return {{32{x[31]}}, x};
	endfunction

endpackage

/* rtl/core/ria_front.sv */
// ria_front: classifies an incoming command into alu, multiply or divide work
// depends on ria_pkg

module ria_front (
	input  ria_pkg::in_t  cmd,
	output ria_pkg::dec_t dec
);

	// class, word form and signedness from the operation code
	always_comb begin
		dec.operation = cmd.operation;
		dec.operand_a = cmd.operand_a;
		dec.operand_b = cmd.operand_b;
		dec.cls  = ria_pkg::CLS_ALU;
		dec.word = 1'b0;
		dec.sgn  = 1'b0;
		case (cmd.operation)
			ria_pkg::OP_MUL, ria_pkg::OP_MULH, ria_pkg::OP_MULHSU,
			ria_pkg::OP_MULHU, ria_pkg::OP_MULW: begin
				dec.cls  = ria_pkg::CLS_MUL;
				dec.word = (cmd.operation == ria_pkg::OP_MULW);
			end
			ria_pkg::OP_DIV, ria_pkg::OP_DIVU, ria_pkg::OP_DIVW, ria_pkg::OP_DIVUW,
			ria_pkg::OP_REM, ria_pkg::OP_REMU, ria_pkg::OP_REMW, ria_pkg::OP_REMUW: begin
				dec.cls  = ria_pkg::CLS_DIV;
				dec.word = cmd.operation inside {ria_pkg::OP_DIVW, ria_pkg::OP_DIVUW,
					ria_pkg::OP_REMW, ria_pkg::OP_REMUW};
				dec.sgn  = cmd.operation inside {ria_pkg::OP_DIV, ria_pkg::OP_DIVW,
					ria_pkg::OP_REM, ria_pkg::OP_REMW};
			end
			default: begin
				dec.cls = ria_pkg::CLS_ALU;
			end
		endcase
	end

endmodule

/* rtl/core/ria_queue.sv */
// ria_queue: small first-in first-out queue of classified entries
// depends on ria_pkg

module ria_queue #(
	parameter int DEPTH = ria_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ria_pkg::dec_t wr_data,
	input  logic          pop,
	output ria_pkg::dec_t rd_data,
	output logic          not_empty,
	output logic          full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	ria_pkg::dec_t    entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign rd_data   = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_FULL);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/ria_back.sv */
// ria_back: executes queued entries: combinational alu with registered result,
// sequenced multiplier, bit-serial divider; depends on ria_pkg

module ria_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ria_pkg::dec_t head,
	input  logic          head_valid,
	output logic          pop,
	output ria_pkg::out_t result,
	output logic          done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DFIN = 2'd3;

	logic [1:0]   state_q;
	logic [4:0]   op_q;
	ria_pkg::out_t result_q;
	logic         done_q;

	// multiplier state
	logic [63:0]  ma_q, mb_q;
	logic [2:0]   mstep_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic [31:0]  mul_x, mul_y;
	logic [127:0] pp_shifted;

	// divider state
	logic [63:0]  rem_q, quo_q, dvs_q;
	logic [5:0]   dcnt_q;
	logic         negq_q, negr_q;
	logic [64:0]  dshift, ddiff;

	// alu and divide-load results
	logic [63:0]  alu_r;
	logic         alu_f;
	logic [63:0]  sa, sb, ua, ub;
	logic         dz, dovf;
	logic [63:0]  dspec_r;
	logic         dspec_f;
	logic [63:0]  mul_r;
	logic         mul_f;
	logic [63:0]  qfin, rfin, div_r;

	assign pop    = (state_q == ST_IDLE) && head_valid;
	assign result = result_q;
	assign done   = done_q;

	// alu operations, combinational
	always_comb begin
		logic [63:0] sum, dif;
		logic [31:0] w;
		sum = head.operand_a + head.operand_b;
		dif = head.operand_a - head.operand_b;
		w   = '0;
		alu_r = '0;
		alu_f = 1'b0;
		case (head.operation)
			ria_pkg::OP_ADD: begin
				alu_r = sum;
				alu_f = (head.operand_a[63] ^ sum[63]) & (head.operand_b[63] ^ sum[63]);
			end
			ria_pkg::OP_ADDW: begin
				alu_r = ria_pkg::sext32(sum[31:0]);
				alu_f = (head.operand_a[31] ^ sum[31]) & (head.operand_b[31] ^ sum[31]);
			end
			ria_pkg::OP_SUB: begin
				alu_r = dif;
				alu_f = (head.operand_a[63] ^ head.operand_b[63]) &
					(head.operand_a[63] ^ dif[63]);
			end
			ria_pkg::OP_SUBW: begin
				alu_r = ria_pkg::sext32(dif[31:0]);
				alu_f = (head.operand_a[31] ^ head.operand_b[31]) &
					(head.operand_a[31] ^ dif[31]);
			end
			ria_pkg::OP_AND: alu_r = head.operand_a & head.operand_b;
			ria_pkg::OP_OR:  alu_r = head.operand_a | head.operand_b;
			ria_pkg::OP_XOR: alu_r = head.operand_a ^ head.operand_b;
			ria_pkg::OP_SLL: alu_r = head.operand_a << head.operand_b[5:0];
			ria_pkg::OP_SRL: alu_r = head.operand_a >> head.operand_b[5:0];
			ria_pkg::OP_SRA: alu_r = 64'($signed(head.operand_a) >>> head.operand_b[5:0]);
			ria_pkg::OP_SLLW: begin
				w = head.operand_a[31:0] << head.operand_b[4:0];
				alu_r = ria_pkg::sext32(w);
			end
			ria_pkg::OP_SRLW: begin
				w = head.operand_a[31:0] >> head.operand_b[4:0];
				alu_r = ria_pkg::sext32(w);
			end
			ria_pkg::OP_SRAW: begin
				w = 32'($signed(head.operand_a[31:0]) >>> head.operand_b[4:0]);
				alu_r = ria_pkg::sext32(w);
			end
			ria_pkg::OP_SLT:
				alu_r = {63'd0, $signed(head.operand_a) < $signed(head.operand_b)};
			ria_pkg::OP_SLTU:
				alu_r = {63'd0, head.operand_a < head.operand_b};
			default: begin
				alu_r = '0;
				alu_f = 1'b0;
			end
		endcase
	end

	// divide operand setup and special cases
	always_comb begin
		logic is_div;
		is_div = head.operation inside {ria_pkg::OP_DIV, ria_pkg::OP_DIVU,
			ria_pkg::OP_DIVW, ria_pkg::OP_DIVUW};
		if (head.word) begin
			sa = head.sgn ? ria_pkg::sext32(head.operand_a[31:0])
				: {32'd0, head.operand_a[31:0]};
			sb = head.sgn ? ria_pkg::sext32(head.operand_b[31:0])
				: {32'd0, head.operand_b[31:0]};
			dz = (head.operand_b[31:0] == 32'd0);
			dovf = head.sgn && (head.operand_a[31:0] == 32'h8000_0000) &&
				(head.operand_b[31:0] == 32'hFFFF_FFFF);
		end else begin
			sa = head.operand_a;
			sb = head.operand_b;
			dz = (head.operand_b == 64'd0);
			dovf = head.sgn && (head.operand_a == ria_pkg::SIGN64) &&
				(head.operand_b == ria_pkg::ALL_ONES);
		end
		ua = (head.sgn && sa[63]) ? (~sa + 64'd1) : sa;
		ub = (head.sgn && sb[63]) ? (~sb + 64'd1) : sb;
		dspec_f = dz || (dovf && is_div);
		if (dz) begin
			if (is_div) begin
				dspec_r = ria_pkg::ALL_ONES;
			end else begin
				dspec_r = head.word ? ria_pkg::sext32(head.operand_a[31:0]) : head.operand_a;
			end
		end else if (is_div) begin
			dspec_r = head.word ? ria_pkg::sext32(head.operand_a[31:0]) : head.operand_a;
		end else begin
			dspec_r = '0;
		end
	end

	// multiplier partial product select and shift
	always_comb begin
		mul_x = mstep_q[1] ? ma_q[63:32] : ma_q[31:0];
		mul_y = mstep_q[0] ? mb_q[63:32] : mb_q[31:0];
		case (mstep_q)
			3'd1:    pp_shifted = {64'd0, pp_q};
			3'd2,
			3'd3:    pp_shifted = {32'd0, pp_q, 32'd0};
			default: pp_shifted = {pp_q, 64'd0};
		endcase
	end

	// multiply result select
	always_comb begin
		mul_r = '0;
		mul_f = 1'b0;
		case (op_q)
			ria_pkg::OP_MUL: begin
				mul_r = acc_q[63:0];
				mul_f = (acc_q[127:64] != {64{acc_q[63]}});
			end
			ria_pkg::OP_MULW: mul_r = ria_pkg::sext32(acc_q[31:0]);
			default:          mul_r = acc_q[127:64];
		endcase
	end

	// divider step and final sign fix
	always_comb begin
		dshift = {rem_q, quo_q[63]};
		ddiff  = dshift - {1'b0, dvs_q};
		qfin   = negq_q ? (~quo_q + 64'd1) : quo_q;
		rfin   = negr_q ? (~rem_q + 64'd1) : rem_q;
		case (op_q)
			ria_pkg::OP_DIV, ria_pkg::OP_DIVU:   div_r = qfin;
			ria_pkg::OP_DIVW, ria_pkg::OP_DIVUW: div_r = ria_pkg::sext32(qfin[31:0]);
			ria_pkg::OP_REMW, ria_pkg::OP_REMUW: div_r = ria_pkg::sext32(rfin[31:0]);
			default:                             div_r = rfin;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q   <= head.operation;
		end
		case (state_q)
			ST_IDLE: begin
				if (pop && head.cls == ria_pkg::CLS_ALU) begin
					result_q.result_value   <= alu_r;
					result_q.exception_flag <= alu_f;
				end else if (pop && head.cls == ria_pkg::CLS_MUL) begin
					ma_q  <= head.operand_a;
					mb_q  <= head.operand_b;
					acc_q <= '0;
				end else if (pop && head.cls == ria_pkg::CLS_DIV) begin
					if (dz || dovf) begin
						result_q.result_value   <= dspec_r;
						result_q.exception_flag <= dspec_f;
					end else begin
						rem_q  <= '0;
						quo_q  <= ua;
						dvs_q  <= ub;
						negq_q <= head.sgn && (sa[63] ^ sb[63]);
						negr_q <= head.sgn && sa[63];
					end
				end
			end
			ST_MUL: begin
				if (mstep_q <= 3'd3) begin
					pp_q <= mul_x * mul_y;
				end
				if (mstep_q >= 3'd1 && mstep_q <= 3'd4) begin
					acc_q <= acc_q + pp_shifted;
				end
				if (mstep_q == 3'd5 && ma_q[63] &&
					(op_q == ria_pkg::OP_MUL || op_q == ria_pkg::OP_MULH ||
					op_q == ria_pkg::OP_MULHSU)) begin
					acc_q[127:64] <= acc_q[127:64] - mb_q;
				end
				if (mstep_q == 3'd6 && mb_q[63] &&
					(op_q == ria_pkg::OP_MUL || op_q == ria_pkg::OP_MULH)) begin
					acc_q[127:64] <= acc_q[127:64] - ma_q;
				end
				if (mstep_q == 3'd7) begin
					result_q.result_value   <= mul_r;
					result_q.exception_flag <= mul_f;
				end
			end
			ST_DIV: begin
				rem_q <= ddiff[64] ? dshift[63:0] : ddiff[63:0];
				quo_q <= {quo_q[62:0], ~ddiff[64]};
			end
			default: begin
				result_q.result_value   <= div_r;
				result_q.exception_flag <= 1'b0;
			end
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mstep_q <= '0;
			dcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.cls)
							ria_pkg::CLS_MUL: begin
								state_q <= ST_MUL;
								mstep_q <= '0;
							end
							ria_pkg::CLS_DIV: begin
								if (dz || dovf) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_DIV;
									dcnt_q  <= '0;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd7) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd63) begin
						state_q <= ST_DFIN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
			endcase
		end
	end

endmodule

/* rtl/core/rv64im_integer_alu_top.sv */
// rv64im_integer_alu_top: rv64im integer alu, front classifier, queue, execute back end
// depends on ria_pkg, ria_front, ria_queue, ria_back
//
// usage:
//   a command (operation, operand_a, operand_b) transfers at a rising edge
//   with start high and busy low. busy is high only while the queue between
//   front and back end is full.
//   each result appears on result for exactly one cycle with done high; the
//   receiver cannot stall, so results are never held back.
//   results come out in command order, one per command.
//   an alu operation passes through the queue and the result register to
//   done; multiply forms four 32x32 partial products, accumulates them and
//   applies two sign corrections; divide and remainder produce one quotient
//   bit per cycle over 64 steps plus load and sign fix, and a zero divisor
//   or signed overflow is answered at load without those steps.
//   throughput: one alu command per cycle while no multiply or divide is in
//   progress; the back end works on one multiply or divide at a time and the
//   queue keeps taking commands until it fills.
//   reset clears the queue and the sequencer; no result is pending after it.

module rv64im_integer_alu_top #(
	parameter int QUEUE_DEPTH = ria_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ria_pkg::in_t  cmd,
	output logic          done,
	output ria_pkg::out_t result
);

	ria_pkg::dec_t dec;
	ria_pkg::dec_t head;
	logic          head_valid;
	logic          pop;
	logic          full;

	assign busy = full;

	ria_front u_front (
		.cmd (cmd),
		.dec (dec)
	);

	ria_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start && !full),
		.wr_data   (dec),
		.pop       (pop),
		.rd_data   (head),
		.not_empty (head_valid),
		.full      (full)
	);

	ria_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result),
		.done       (done)
	);

endmodule

/* verif/tb_rv64im_integer_alu_top.sv */
// tb_rv64im_integer_alu_top: self-checking testbench for the rv64im integer alu
// depends on ria_pkg and rv64im_integer_alu_top; predicts each result and checks it in order

module tb_rv64im_integer_alu_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	ria_pkg::in_t cmd = '0;
	logic done;
	ria_pkg::out_t result;

	ria_pkg::out_t expected_results[$];
	int error_count = 0;
	int result_count = 0;
	int transfer_count = 0;
	int idle_pct = 29;

	rv64im_integer_alu_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	// sign-extend the low word
	function automatic logic [63:0] word_ext(input logic [63:0] x);
		return {{32{x[31]}}, x[31:0]};
	endfunction

	// compute the alu result and flag for one command
	function automatic ria_pkg::out_t alu_predict(input ria_pkg::in_t c);
		logic [63:0] a, b, aw, bw, r, t;
		logic [127:0] prod_ss, prod_su, prod_uu;
		logic f;
		a = c.operand_a;
		b = c.operand_b;
		aw = word_ext(a);
		bw = word_ext(b);
		r = '0;
		f = 1'b0;
		prod_ss = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
		prod_su = {{64{a[63]}}, a} * {64'd0, b};
		prod_uu = {64'd0, a} * {64'd0, b};
		case (c.operation)
			ria_pkg::OP_ADD: begin
				r = a + b;
				f = (a[63] ~^ b[63]) && (r[63] != a[63]);
			end
			ria_pkg::OP_ADDW: begin
				t = word_ext(a + b);
				r = t;
				f = (aw[63] ~^ bw[63]) && (t[63] != aw[63]);
			end
			ria_pkg::OP_SUB: begin
				r = a - b;
				f = (a[63] ^ b[63]) && (r[63] != a[63]);
			end
			ria_pkg::OP_SUBW: begin
				t = word_ext(a - b);
				r = t;
				f = (aw[63] ^ bw[63]) && (t[63] != aw[63]);
			end
			ria_pkg::OP_AND: r = a & b;
			ria_pkg::OP_OR: r = a | b;
			ria_pkg::OP_XOR: r = a ^ b;
			ria_pkg::OP_SLL: r = a << b[5:0];
			ria_pkg::OP_SRL: r = a >> b[5:0];
			ria_pkg::OP_SRA: r = $signed(a) >>> b[5:0];
			ria_pkg::OP_SLLW: r = word_ext({32'd0, a[31:0]} << b[4:0]);
			ria_pkg::OP_SRLW: r = word_ext({32'd0, a[31:0]} >> b[4:0]);
			ria_pkg::OP_SRAW: r = word_ext($signed(aw) >>> b[4:0]);
			ria_pkg::OP_SLT: r = {63'd0, $signed(a) < $signed(b)};
			ria_pkg::OP_SLTU: r = {63'd0, a < b};
			ria_pkg::OP_MUL: begin
				r = prod_ss[63:0];
				f = prod_ss[127:64] != {64{r[63]}};
			end
			ria_pkg::OP_MULH: r = prod_ss[127:64];
			ria_pkg::OP_MULHSU: r = prod_su[127:64];
			ria_pkg::OP_MULHU: r = prod_uu[127:64];
			ria_pkg::OP_MULW: r = word_ext(a[31:0] * b[31:0]);
			ria_pkg::OP_DIV: begin
				if (b == 0) begin
					r = ria_pkg::ALL_ONES;
					f = 1'b1;
				end else if (a == ria_pkg::SIGN64 && b == ria_pkg::ALL_ONES) begin
					r = a;
					f = 1'b1;
				end else r = $signed(a) / $signed(b);
			end
			ria_pkg::OP_DIVU: begin
				if (b == 0) begin
					r = ria_pkg::ALL_ONES;
					f = 1'b1;
				end else r = a / b;
			end
			ria_pkg::OP_DIVW: begin
				if (bw == 0) begin
					r = ria_pkg::ALL_ONES;
					f = 1'b1;
				end else if (aw == 64'hFFFF_FFFF_8000_0000 && bw == ria_pkg::ALL_ONES) begin
					r = aw;
					f = 1'b1;
				end else r = word_ext($signed(aw) / $signed(bw));
			end
			ria_pkg::OP_DIVUW: begin
				if (b[31:0] == 0) begin
					r = ria_pkg::ALL_ONES;
					f = 1'b1;
				end else r = word_ext({32'd0, a[31:0] / b[31:0]});
			end
			ria_pkg::OP_REM: begin
				if (b == 0) begin
					r = a;
					f = 1'b1;
				end else if (a == ria_pkg::SIGN64 && b == ria_pkg::ALL_ONES) r = '0;
				else r = $signed(a) % $signed(b);
			end
			ria_pkg::OP_REMU: begin
				if (b == 0) begin
					r = a;
					f = 1'b1;
				end else r = a % b;
			end
			ria_pkg::OP_REMW: begin
				if (bw == 0) begin
					r = aw;
					f = 1'b1;
				end else if (aw == 64'hFFFF_FFFF_8000_0000 && bw == ria_pkg::ALL_ONES) r = '0;
				else r = word_ext($signed(aw) % $signed(bw));
			end
			ria_pkg::OP_REMUW: begin
				if (b[31:0] == 0) begin
					r = aw;
					f = 1'b1;
				end else r = word_ext({32'd0, a[31:0] % b[31:0]});
			end
			default: begin
				r = '0;
				f = 1'b0;
			end
		endcase
		alu_predict.result_value = r;
		alu_predict.exception_flag = f;
	endfunction

	// one command transfer, with optional idle cycles before it
	task automatic send_cmd(input logic [4:0] op, input logic [63:0] a, input logic [63:0] b);
		ria_pkg::in_t c;
		c.operation = op;
		c.operand_a = a;
		c.operand_b = b;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(alu_predict(c));
		transfer_count++;
	endtask

	task automatic release_start();
		start <= 1'b0;
		@(posedge clk);
	endtask

	// check each result against the oldest prediction
	always @(posedge clk) begin
		ria_pkg::out_t exp_r;
		if (arst_n && done) begin
			result_count++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h flag %b", $time,
					result.result_value, result.exception_flag);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.result_value !== exp_r.result_value) begin
					$display("%0t: result_value expected %h actual %h", $time,
						exp_r.result_value, result.result_value);
					error_count++;
				end
				if (result.exception_flag !== exp_r.exception_flag) begin
					$display("%0t: exception_flag expected %b actual %b", $time,
						exp_r.exception_flag, result.exception_flag);
					error_count++;
				end
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// operand with a bias toward edge values
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return ria_pkg::ALL_ONES;
			2: return ria_pkg::SIGN64;
			3: return 64'h7FFF_FFFF_FFFF_FFFF;
			4: return word_ext({32'd0, $urandom()});
			5: return {32'd0, $urandom()};
			6: return 64'(int'($urandom_range(0, 20)) - 10);
			7: return {$urandom(), 32'd0};
			default: return rand64();
		endcase
	endfunction

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// edge operands for every operation code, unused codes included
	task automatic test_directed_edges();
		logic [63:0] edges[4];
		edges = '{64'd0, ria_pkg::ALL_ONES, ria_pkg::SIGN64, 64'h7FFF_FFFF_FFFF_FFFF};
		for (int op = 0; op < 32; op++)
			send_cmd(5'(op), edges[op % 4], edges[(op / 4) % 4]);
		release_start();
	endtask

	// divide corner cases: zero divisor and signed overflow, full and word width; also SRLW, SRA and SLLW shift edges
	task automatic test_divide_corners();
		send_cmd(ria_pkg::OP_DIV, ria_pkg::SIGN64, ria_pkg::ALL_ONES);
		send_cmd(ria_pkg::OP_REM, ria_pkg::SIGN64, ria_pkg::ALL_ONES);
		send_cmd(ria_pkg::OP_DIVW, 64'h1234_5678_8000_0000, 64'h0000_0001_FFFF_FFFF);
		send_cmd(ria_pkg::OP_REMW, 64'h0000_0000_8000_0000, ria_pkg::ALL_ONES);
		send_cmd(ria_pkg::OP_DIVU, 64'd77, 64'd0);
		send_cmd(ria_pkg::OP_REMU, 64'd77, 64'd0);
		send_cmd(ria_pkg::OP_DIVUW, ria_pkg::ALL_ONES, 64'hFFFF_FFFF_0000_0000);
		send_cmd(ria_pkg::OP_REMUW, 64'h0000_0000_8000_0001, 64'h5_0000_0000);
		send_cmd(ria_pkg::OP_REMW, 64'hDEAD_BEEF_C000_0000, 64'h7_0000_0000);
		send_cmd(ria_pkg::OP_SRLW, 64'h0000_0000_8000_0000, 64'd0);
		send_cmd(ria_pkg::OP_SRA, ria_pkg::SIGN64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(ria_pkg::OP_SLLW, 64'd1, 64'd31);
		release_start();
	endtask

	// random commands, mostly defined codes, with a no-idle stretch and a drain a quarter of the way through
	task automatic test_random_mix(input int count);
		logic [4:0] op;
		for (int i = 0; i < count; i++) begin
			idle_pct = (i >= count / 3 && i < count / 2) ? 0 : 29;
			op = ($urandom_range(99) < 95) ? 5'($urandom_range(0, 27))
				: 5'($urandom_range(28, 31));
			send_cmd(op, pick_operand(), pick_operand());
			if (i == count / 4) wait_drained();
		end
		idle_pct = 29;
		release_start();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_divide_corners();
		wait_drained();
		test_random_mix(1350);
		wait_drained();
		repeat (80) @(posedge clk);
		$display("covered %0d command transfers over all operation codes, %0d results checked",
			transfer_count, result_count);
		$display("edge operands, zero divisors and signed divide overflow were included");
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

endmodule
